>>> rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the timed event scheduler
// Entry layout, operation and status codes, configuration indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int unsigned QueueDepthDef   = 32;
  // handler count, a power of two no larger than 2^8
  localparam int unsigned HandlerCountDef = 256;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned SliceW   = 31;
  localparam int unsigned IdCtrW   = 24;
  localparam int unsigned IdShift  = 8;

  localparam logic [SliceW-1:0] MaxSliceRst = {SliceW{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_MAX_SLICE    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_TIMER_NUMBER = CfgIdxW'(1);

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_CANCEL  = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [63:0] due;
    logic [63:0] param;
    logic [7:0]  handler;
    logic [31:0] id;
  } tes_entry_t;

  // memory port controls
  typedef struct packed {
    logic re_a;
    logic re_b;
    logic we;
  } tes_mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tes_if.sv
// ----------------------------------------------------------------------------
// tes_if: stream interfaces of the timed event scheduler
// Input operation channel and result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  handler;
  logic [63:0] event_param;
  logic [31:0] delay;
  logic [31:0] cancel_id;
  logic [30:0] elapsed;

  modport source (output valid, mode, handler, event_param, delay, cancel_id, elapsed,
                  input ready);
  modport sink   (input valid, mode, handler, event_param, delay, cancel_id, elapsed,
                  output ready);
endinterface

interface tes_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  fired_handler;
  logic [63:0] fired_param;
  logic [31:0] event_id;
  logic [30:0] lateness;
  logic [30:0] slice_len;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, fired_handler, fired_param, event_id, lateness,
                  slice_len, status, last, input ready);
  modport sink   (input valid, kind, fired_handler, fired_param, event_id, lateness,
                  slice_len, status, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tes_mem.sv
// ----------------------------------------------------------------------------
// tes_mem: heap entry store
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_mem import tes_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic         clk_i,
  input  wire tes_mem_ctl_t ctl_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire tes_entry_t   wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output tes_entry_t        rdata_a_o,
  output tes_entry_t        rdata_b_o
);

  tes_entry_t mem_q [Depth];
  tes_entry_t rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re_a) begin
      rd_a_q <= mem_q[raddr_a_i];
    end
    if (ctl_i.re_b) begin
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

>>> rtl/core/timed_event_scheduler.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler: binary min-heap event scheduler for one timer
// Pending events kept in a heap memory keyed by due time; add, cancel and
// advance operations with a status beat carrying the next slice length.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      beats per operation
//  in_i     in   valid/ready    1
//  out_o    out  valid/ready    fired events (advance only), then 1 status
//  cfg      in   cfg_we_i       1 register write, no wait
//
//  Steps after the accepting edge: add compares the new entry with one
//  parent at a time while climbing, then writes it, reads the root and
//  sends status. Cancel scans ids one a cycle, fills the hole with the last
//  entry and sifts down each node from the last parent back to the root.
//  Advance checks the root and sifts down the refilled root after each
//  fired event. The single heap memory (one write port) serialises these steps.
//  Reset clears the counters; memory contents need no clear.
//  A stalled result holds in the output register; the sequencer waits there.
//
`default_nettype none

module timed_event_scheduler import tes_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tes_in_if.sink                   in_i,
  tes_out_if.source                out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW  = AddrW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_SCAN, S_MOVE, S_RB, S_SD_X, S_SD_CMP, S_FIN,
    S_POP_CHK, S_POP, S_ROOT, S_STAT
  } state_e;

  // what follows once a sift is finished
  typedef enum logic [1:0] {CTX_ROOT, CTX_REBUILD, CTX_POP} ctx_e;

  state_e             state_q;
  ctx_e               ctx_q;
  logic [63:0]        now_q;
  logic [IdCtrW-1:0]  idctr_q;
  logic [CntW-1:0]    count_q;
  logic [SliceW-1:0]  max_q;
  logic [7:0]         timer_q;
  logic [AddrW-1:0]   hole_q, rb_q, scan_q;
  logic               rvalid_q;
  tes_entry_t         x_q;
  logic [31:0]        want_q;
  logic [1:0]         st_q;
  logic [31:0]        nid_q;

  // output register
  logic               out_valid_q;
  logic               out_kind_q;
  logic [7:0]         out_hnd_q;
  logic [63:0]        out_param_q;
  logic [31:0]        out_id_q;
  logic [30:0]        out_late_q;
  logic [30:0]        out_slice_q;
  logic [1:0]         out_st_q;

  tes_mem_ctl_t       mctl;
  logic [AddrW-1:0]   waddr, raddr_a, raddr_b;
  tes_entry_t         wdata, rd_a, rd_b;

  tes_mem #(.Depth(QueueDepth)) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mctl),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  logic             in_acc, out_free, out_load;
  tes_entry_t       new_ent;
  logic [IdxW-1:0]  cnt_x, hl, hr, c_idx, cl, cr;
  logic [AddrW-1:0] par_in, par_h, par2, c_addr, last_addr;
  logic             up_move, l_lt, r_lt, c_sel, due_now, scan_more, id_hit;
  logic [63:0]      sdue, diff, late_w;
  logic [30:0]      slice_w, late_sat;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // a new beat enters the output register this cycle
  assign out_load = out_free && ((state_q == S_STAT) || (state_q == S_POP && due_now));

  always_comb begin
    new_ent.due     = now_q + 64'(in_i.delay);
    new_ent.param   = in_i.event_param;
    // handler count is a power of two, so this is a plain mask
    new_ent.handler = 8'(32'(in_i.handler) % HandlerCountDef);
    new_ent.id      = {idctr_q, timer_q};
  end

  // heap index arithmetic
  assign cnt_x     = IdxW'(count_q);
  assign par_in    = AddrW'((count_q - CntW'(1)) >> 1);
  assign par_h     = AddrW'((hole_q - AddrW'(1)) >> 1);
  assign par2      = AddrW'((par_h - AddrW'(1)) >> 1);
  assign last_addr = AddrW'(count_q - CntW'(1));
  assign hl        = {1'b0, hole_q, 1'b1};
  assign hr        = hl + IdxW'(1);

  // child selection, strict compares as in a swap sift
  assign up_move = rd_a.due > x_q.due;
  assign l_lt    = x_q.due > rd_a.due;
  assign sdue    = l_lt ? rd_a.due : x_q.due;
  assign r_lt    = rvalid_q && (sdue > rd_b.due);
  assign c_sel   = l_lt || r_lt;
  assign c_idx   = r_lt ? hr : hl;
  assign c_addr  = c_idx[AddrW-1:0];
  assign cl      = {1'b0, c_addr, 1'b1};
  assign cr      = cl + IdxW'(1);

  assign id_hit    = rd_a.id == want_q;
  assign scan_more = (CntW'(scan_q) + CntW'(1)) < count_q;
  assign due_now   = rd_a.due <= now_q;

  // slice and lateness
  assign diff     = rd_a.due - now_q;
  assign late_w   = now_q - rd_a.due;
  assign late_sat = (|late_w[63:31]) ? 31'h7FFF_FFFF : late_w[30:0];

  always_comb begin
    if (count_q == '0) begin
      slice_w = max_q;
    end else if (due_now) begin
      slice_w = '0;
    end else if (diff < {33'd0, max_q}) begin
      slice_w = diff[30:0];
    end else begin
      slice_w = max_q;
    end
  end

  // memory commands
  always_comb begin
    mctl    = '0;
    waddr   = hole_q;
    wdata   = x_q;
    raddr_a = '0;
    raddr_b = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.mode == MODE_ADD && count_q < CntW'(QueueDepth)) begin
          if (count_q == '0) begin
            mctl.we = 1'b1;
            waddr   = '0;
            wdata   = new_ent;
          end else begin
            mctl.re_a = 1'b1;
            raddr_a   = par_in;
          end
        end else if (in_acc && in_i.mode == MODE_CANCEL && count_q != '0) begin
          mctl.re_a = 1'b1;
        end
      end
      S_UP: begin
        if (up_move) begin
          mctl.we = 1'b1;
          wdata   = rd_a;
          if (par_h != '0) begin
            mctl.re_a = 1'b1;
            raddr_a   = par2;
          end
        end
      end
      S_SCAN: begin
        if (id_hit) begin
          if (scan_q != last_addr) begin
            mctl.re_a = 1'b1;
            raddr_a   = last_addr;
          end
        end else if (scan_more) begin
          mctl.re_a = 1'b1;
          raddr_a   = scan_q + AddrW'(1);
        end
      end
      S_MOVE: begin
        mctl.we = 1'b1;
        wdata   = rd_a;
      end
      S_RB: begin
        if (count_q >= CntW'(2)) begin
          mctl.re_a = 1'b1;
          raddr_a   = rb_q;
        end
      end
      S_SD_X: begin
        if (hl < cnt_x) begin
          mctl.re_a = 1'b1;
          raddr_a   = hl[AddrW-1:0];
          mctl.re_b = hr < cnt_x;
          raddr_b   = hr[AddrW-1:0];
        end
      end
      S_SD_CMP: begin
        if (c_sel) begin
          mctl.we = 1'b1;
          wdata   = r_lt ? rd_b : rd_a;
          if (cl < cnt_x) begin
            mctl.re_a = 1'b1;
            raddr_a   = cl[AddrW-1:0];
            mctl.re_b = cr < cnt_x;
            raddr_b   = cr[AddrW-1:0];
          end
        end
      end
      S_FIN: begin
        mctl.we = 1'b1;
      end
      S_POP_CHK, S_ROOT: begin
        mctl.re_a = count_q != '0;
      end
      S_POP: begin
        if (due_now && out_free && count_q > CntW'(1)) begin
          mctl.re_a = 1'b1;
          raddr_a   = last_addr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctx_q       <= CTX_ROOT;
      now_q       <= '0;
      idctr_q     <= '0;
      count_q     <= '0;
      max_q       <= MaxSliceRst;
      timer_q     <= '0;
      hole_q      <= '0;
      rb_q        <= '0;
      scan_q      <= '0;
      rvalid_q    <= 1'b0;
      x_q         <= '0;
      want_q      <= '0;
      st_q        <= STATUS_OK;
      nid_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_STATUS;
      out_hnd_q   <= '0;
      out_param_q <= '0;
      out_id_q    <= '0;
      out_late_q  <= '0;
      out_slice_q <= '0;
      out_st_q    <= STATUS_OK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_SLICE:    max_q   <= cfg_wdata_i;
          CFG_TIMER_NUMBER: timer_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ctx_q <= CTX_ROOT;
            case (in_i.mode)
              MODE_ADD: begin
                if (count_q >= CntW'(QueueDepth)) begin
                  st_q    <= STATUS_FULL;
                  nid_q   <= '0;
                  state_q <= S_ROOT;
                end else begin
                  st_q    <= STATUS_OK;
                  nid_q   <= new_ent.id;
                  idctr_q <= idctr_q + IdCtrW'(1);
                  count_q <= count_q + CntW'(1);
                  x_q     <= new_ent;
                  hole_q  <= AddrW'(count_q);
                  state_q <= (count_q == '0) ? S_ROOT : S_UP;
                end
              end
              MODE_CANCEL: begin
                st_q    <= STATUS_NOTFOUND;
                nid_q   <= '0;
                want_q  <= in_i.cancel_id;
                scan_q  <= '0;
                state_q <= (count_q == '0) ? S_ROOT : S_SCAN;
              end
              MODE_ADVANCE: begin
                st_q    <= STATUS_OK;
                nid_q   <= '0;
                now_q   <= now_q + 64'(in_i.elapsed);
                state_q <= S_POP_CHK;
              end
              default: begin
                st_q    <= STATUS_OK;
                nid_q   <= '0;
                state_q <= S_ROOT;
              end
            endcase
          end
        end
        S_UP: begin
          if (up_move) begin
            hole_q <= par_h;
            if (par_h == '0) begin
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SCAN: begin
          if (id_hit) begin
            st_q    <= STATUS_OK;
            count_q <= count_q - CntW'(1);
            hole_q  <= scan_q;
            rb_q    <= AddrW'((count_q - CntW'(1)) >> 1);
            state_q <= (scan_q == last_addr) ? S_RB : S_MOVE;
          end else if (scan_more) begin
            scan_q <= scan_q + AddrW'(1);
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_MOVE: state_q <= S_RB;
        S_RB: begin
          if (count_q < CntW'(2)) begin
            state_q <= S_ROOT;
          end else begin
            hole_q  <= rb_q;
            ctx_q   <= CTX_REBUILD;
            state_q <= S_SD_X;
          end
        end
        S_SD_X: begin
          x_q <= rd_a;
          if (hl < cnt_x) begin
            rvalid_q <= hr < cnt_x;
            state_q  <= S_SD_CMP;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_SD_CMP: begin
          if (c_sel) begin
            hole_q   <= c_addr;
            rvalid_q <= cr < cnt_x;
            if (!(cl < cnt_x)) begin
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          case (ctx_q)
            CTX_REBUILD: begin
              if (rb_q == '0) begin
                state_q <= S_ROOT;
              end else begin
                rb_q    <= rb_q - AddrW'(1);
                state_q <= S_RB;
              end
            end
            CTX_POP: state_q <= S_POP_CHK;
            default: state_q <= S_ROOT;
          endcase
        end
        S_POP_CHK: state_q <= (count_q == '0) ? S_STAT : S_POP;
        S_POP: begin
          if (!due_now) begin
            state_q <= S_STAT;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_FIRED;
            out_hnd_q   <= rd_a.handler;
            out_param_q <= rd_a.param;
            out_id_q    <= rd_a.id;
            out_late_q  <= late_sat;
            out_slice_q <= '0;
            out_st_q    <= STATUS_OK;
            count_q     <= count_q - CntW'(1);
            if (count_q > CntW'(1)) begin
              hole_q  <= '0;
              ctx_q   <= CTX_POP;
              state_q <= S_SD_X;
            end else begin
              state_q <= S_POP_CHK;
            end
          end
        end
        S_ROOT: state_q <= S_STAT;
        S_STAT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_STATUS;
            out_hnd_q   <= '0;
            out_param_q <= '0;
            out_id_q    <= nid_q;
            out_late_q  <= '0;
            out_slice_q <= slice_w;
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.fired_handler = out_hnd_q;
  assign out_o.fired_param   = out_param_q;
  assign out_o.event_id      = out_id_q;
  assign out_o.lateness      = out_late_q;
  assign out_o.slice_len     = out_slice_q;
  assign out_o.status        = out_st_q;
  assign out_o.last          = out_kind_q;

endmodule

`default_nettype wire

>>> rtl/core/tes_checker.sv
// ----------------------------------------------------------------------------
// tes_checker: port-level checks for the timed event scheduler
// Watches result beats and input acceptance; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_checker import tes_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [31:0] out_event_id,
  input wire logic [30:0] out_slice,
  input wire logic [1:0]  out_status,
  input wire logic        out_last
);

  // only the status beat closes an operation
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == out_kind))
    else $error("last flag disagrees with beat kind");

  // fired beats carry no slice and no error
  a_fired_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_kind == KIND_FIRED) |-> (out_slice == '0 && out_status == STATUS_OK))
    else $error("fired beat carries status fields");

  // a failed operation (dropped add or unknown cancel) issues no id
  a_full_noid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_kind == KIND_STATUS && out_status != STATUS_OK) |-> out_event_id == '0)
    else $error("failed operation reports an id");

  // one operation at a time
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_id)))
    else $error("stalled result beat changed");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_kind     (out_o.kind),
  .out_event_id (out_o.event_id),
  .out_slice    (out_o.slice_len),
  .out_status   (out_o.status),
  .out_last     (out_o.last)
);

`default_nettype wire

>>> test/timed_event_scheduler_tb.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler_tb: self-checking bench for the event scheduler
// Drives add, cancel and advance operations through bursty valid/ready
// traffic, predicts every fired and status beat with a local heap model and
// compares field by field. Registers are rewritten between idle phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module timed_event_scheduler_tb;
  import tes_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned MaxErrShown = 10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  handler;
    logic [63:0] event_param;
    logic [31:0] delay;
    logic [31:0] cancel_id;
    logic [30:0] elapsed;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_handler;
    logic [63:0] fired_param;
    logic [31:0] event_id;
    logic [30:0] lateness;
    logic [30:0] slice_len;
    logic [1:0]  status;
    logic        last;
  } beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  tes_in_if  op_ch ();
  tes_out_if res_ch ();

  timed_event_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (op_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Scheduler shadow: heap, timestamp, id counter and register copies
  // --------------------------------------------------------------------------
  logic [30:0] sh_max_slice;
  logic [7:0]  sh_timer_num;
  logic [63:0] sh_now;
  logic [23:0] sh_id_ctr;
  int unsigned sh_count;
  logic [63:0] sh_due     [Depth];
  logic [63:0] sh_param   [Depth];
  logic [7:0]  sh_handler [Depth];
  logic [31:0] sh_id      [Depth];

  op_t   pending_ops[$];   // items waiting for the driver
  beat_t expected_beats[$];
  logic [31:0] live_ids[$]; // ids believed to be in the heap (for cancels)

  int unsigned mismatches;
  int unsigned beats_seen;

  task automatic swap_slots(int unsigned a, int unsigned b);
    logic [63:0] d, p;
    logic [7:0]  h;
    logic [31:0] i;
    d = sh_due[a]; p = sh_param[a]; h = sh_handler[a]; i = sh_id[a];
    sh_due[a] = sh_due[b]; sh_param[a] = sh_param[b];
    sh_handler[a] = sh_handler[b]; sh_id[a] = sh_id[b];
    sh_due[b] = d; sh_param[b] = p; sh_handler[b] = h; sh_id[b] = i;
  endtask

  task automatic sink_slot(int unsigned start);
    int unsigned i, l, r, s;
    i = start;
    forever begin
      l = 2 * i + 1; r = l + 1; s = i;
      if (l < sh_count && sh_due[s] > sh_due[l]) s = l;
      if (r < sh_count && sh_due[s] > sh_due[r]) s = r;
      if (s == i) break;
      swap_slots(i, s);
      i = s;
    end
  endtask

  function automatic logic [30:0] next_slice();
    logic [63:0] d;
    if (sh_count == 0) return sh_max_slice;
    if (sh_due[0] <= sh_now) return '0;
    d = sh_due[0] - sh_now;
    return (d < 64'(sh_max_slice)) ? d[30:0] : sh_max_slice;
  endfunction

  // works out every beat an operation causes and queues them
  task automatic schedule_op(op_t op);
    logic [31:0] new_id;
    logic [1:0]  st;
    logic [63:0] late;
    int unsigned i, p;
    beat_t b;
    new_id = '0;
    st = STATUS_OK;
    if (op.mode == MODE_ADD) begin
      if (sh_count >= Depth) begin
        st = STATUS_FULL;
      end else begin
        i = sh_count;
        sh_count++;
        new_id = {sh_id_ctr, sh_timer_num};
        sh_id_ctr++;
        sh_due[i] = sh_now + 64'(op.delay);
        sh_param[i] = op.event_param;
        sh_handler[i] = op.handler;
        sh_id[i] = new_id;
        live_ids.push_back(new_id);
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!(sh_due[p] > sh_due[i])) break;
          swap_slots(p, i);
          i = p;
        end
      end
    end else if (op.mode == MODE_CANCEL) begin
      st = STATUS_NOTFOUND;
      for (i = 0; i < sh_count; i++) begin
        if (sh_id[i] == op.cancel_id) begin
          sh_count--;
          if (i != sh_count) begin
            sh_due[i] = sh_due[sh_count]; sh_param[i] = sh_param[sh_count];
            sh_handler[i] = sh_handler[sh_count]; sh_id[i] = sh_id[sh_count];
          end
          // full rebuild, bottom-up
          if (sh_count >= 2) begin
            for (p = sh_count / 2 + 1; p > 0; p--) sink_slot(p - 1);
          end
          st = STATUS_OK;
          break;
        end
      end
    end else if (op.mode == MODE_ADVANCE) begin
      sh_now += 64'(op.elapsed);
      while (sh_count > 0 && sh_due[0] <= sh_now) begin
        late = sh_now - sh_due[0];
        if (late > 64'h7FFF_FFFF) late = 64'h7FFF_FFFF;
        b = '0;
        b.kind = KIND_FIRED;
        b.fired_handler = sh_handler[0];
        b.fired_param = sh_param[0];
        b.event_id = sh_id[0];
        b.lateness = late[30:0];
        expected_beats.push_back(b);
        sh_count--;
        sh_due[0] = sh_due[sh_count]; sh_param[0] = sh_param[sh_count];
        sh_handler[0] = sh_handler[sh_count]; sh_id[0] = sh_id[sh_count];
        sink_slot(0);
      end
    end
    b = '0;
    b.kind = KIND_STATUS;
    b.event_id = new_id;
    b.slice_len = next_slice();
    b.status = st;
    b.last = 1'b1;
    expected_beats.push_back(b);
  endtask

  // --------------------------------------------------------------------------
  // Clock and stimulus control
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // driver: bursts of random length, random gaps; predicts at acceptance
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_ch.valid <= 1'b0;
      {op_ch.mode, op_ch.handler, op_ch.event_param, op_ch.delay,
       op_ch.cancel_id, op_ch.elapsed} <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (op_ch.valid && op_ch.ready) begin
        schedule_op(pending_ops.pop_front());
      end
      if (op_ch.valid && !op_ch.ready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        op_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0) begin
        op_ch.valid <= 1'b1;
        {op_ch.mode, op_ch.handler, op_ch.event_param, op_ch.delay,
         op_ch.cancel_id, op_ch.elapsed} <= pending_ops[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        op_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern; a long hold-off when asked
  int unsigned stall_mode;
  int unsigned hold_cycles;
  bit          hold_req;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles < 300) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // monitor: compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.kind, res_ch.fired_handler, res_ch.fired_param, res_ch.event_id,
             res_ch.lateness, res_ch.slice_len, res_ch.status, res_ch.last};
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxErrShown) $display("unexpected beat %h", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxErrShown) begin
            $display("beat %0d mismatch", beats_seen);
            $display("  exp kind %0d h %0d p %h id %h late %0d slice %0d st %0d last %0d",
                     want.kind, want.fired_handler, want.fired_param, want.event_id,
                     want.lateness, want.slice_len, want.status, want.last);
            $display("  got kind %0d h %0d p %h id %h late %0d slice %0d st %0d last %0d",
                     got.kind, got.fired_handler, got.fired_param, got.event_id,
                     got.lateness, got.slice_len, got.status, got.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic op_t mk_add(logic [31:0] dly);
    op_t o;
    o = '0;
    o.mode = MODE_ADD;
    o.handler = 8'($urandom);
    o.event_param = {$urandom, $urandom};
    o.delay = dly;
    return o;
  endfunction

  function automatic op_t mk_adv(logic [30:0] el);
    op_t o;
    o = '0;
    o.mode = MODE_ADVANCE;
    o.elapsed = el;
    return o;
  endfunction

  function automatic op_t mk_cancel(logic [31:0] id);
    op_t o;
    o = '0;
    o.mode = MODE_CANCEL;
    o.cancel_id = id;
    return o;
  endfunction

  // noise in the unused fields keeps every input bit toggling
  function automatic op_t salt(op_t o);
    op_t r;
    r = op_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.mode = o.mode;
    if (o.mode == MODE_ADD) begin
      r.handler = o.handler; r.event_param = o.event_param; r.delay = o.delay;
    end else if (o.mode == MODE_CANCEL) begin
      r.cancel_id = o.cancel_id;
    end else if (o.mode == MODE_ADVANCE) begin
      r.elapsed = o.elapsed;
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || op_ch.valid || expected_beats.size() > 0)
      @(posedge clk_i);
    // quiet spell before any register write
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_SLICE) sh_max_slice = val;
    else sh_timer_num = val[7:0];
  endtask

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom;
      2: return 0;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    op_t o;
    int unsigned k, c;
    k = 0;
    while (k < n) begin
      c = $urandom_range(0, 9);
      if (c < 4) begin
        o = mk_add(pick_delay());
      end else if (c < 6) begin
        if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
          o = mk_cancel(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        else
          o = mk_cancel($urandom);
      end else if (c < 9) begin
        o = mk_adv(($urandom_range(0, 7) == 0) ? 31'h7FFF_FFFF :
                   31'($urandom_range(0, 300)));
      end else begin
        o = '0;
        o.mode = MODE_NOP;   // status beat only
      end
      pending_ops.push_back(salt(o));
      k++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned i;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    stall_mode = 0;
    hold_req = 1'b0;
    mismatches = 0;
    beats_seen = 0;
    sh_max_slice = MaxSliceRst;
    sh_timer_num = '0;
    sh_now = '0;
    sh_id_ctr = '0;
    sh_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: empty advance, extremes, unknown cancel, no-op, late firing
    pending_ops.push_back(salt(mk_adv(0)));
    pending_ops.push_back(salt(mk_cancel(32'hFFFF_FFFF)));
    pending_ops.push_back(salt(mk_add(0)));
    pending_ops.push_back(salt(mk_add(32'hFFFF_FFFF)));
    pending_ops.push_back(salt(mk_add(5)));
    pending_ops.push_back(salt(mk_add(5)));   // equal due times
    pending_ops.push_back(salt(mk_cancel(32'h0000_0100)));
    pending_ops.push_back(salt(mk_cancel(32'h0000_0100)));
    pending_ops.push_back(salt(mk_adv(31'h7FFF_FFFF)));
    pending_ops.push_back(salt({MODE_NOP, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 31'h7FFF_FFFF}));
    wait_idle();

    // small slice, timer byte at top; fill the heap past full
    write_reg(CFG_MAX_SLICE, 31'd1);
    write_reg(CFG_TIMER_NUMBER, 8'hFF);
    for (i = 0; i < 34; i++) pending_ops.push_back(salt(mk_add($urandom_range(0, 60))));
    // long receiver hold-off while the sender keeps going: fires many at once
    pending_ops.push_back(salt(mk_adv(31'd100)));
    hold_req = 1'b1;
    wait_idle();
    hold_req = 1'b0;

    write_reg(CFG_MAX_SLICE, 31'h7FFF_FFFF);
    write_reg(CFG_TIMER_NUMBER, 8'h00);
    stall_mode = 1;
    random_phase(45);
    wait_idle();

    write_reg(CFG_MAX_SLICE, 31'd150);
    write_reg(CFG_TIMER_NUMBER, 8'h5A);
    stall_mode = 2;
    random_phase(45);
    wait_idle();

    write_reg(CFG_MAX_SLICE, 31'd0);   // slice always reads zero
    write_reg(CFG_TIMER_NUMBER, 8'hA5);
    stall_mode = 0;
    random_phase(30);
    pending_ops.push_back(salt(mk_adv(31'h7FFF_FFFF)));
    pending_ops.push_back(salt(mk_adv(31'h7FFF_FFFF)));
    pending_ops.push_back(salt(mk_adv(31'h7FFF_FFFF)));
    wait_idle();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
